### hw/rtl/arpm_pkg.sv
// ----------------------------------------------------------------------------
// arpm_pkg
// types and constants shared by the level meter and its checker
// ----------------------------------------------------------------------------
package arpm_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               has_sample;
    logic               last;
  } arpm_in_t;

  typedef struct packed {
    logic [23:0]        rms_counts_q8;
    logic signed [15:0] dbfs_q8;
    logic [14:0]        peak_abs;
    logic               online;
  } arpm_out_t;

  localparam logic signed [15:0] DB_FLOOR_Q8 = -16'sd30720;
  localparam logic [17:0]        DB_COEF_Q16 = 18'd197283;
  localparam logic [21:0]        LOG_TOP_Q16 = 22'd3014656;  // 46 << 16
  localparam int unsigned        SUM_W       = 64;

endpackage

### hw/rtl/audio_rms_peak_dbfs_meter.sv
// ----------------------------------------------------------------------------
// audio_rms_peak_dbfs_meter
// rms, peak and dbfs level meter over a window of audio frames
// ----------------------------------------------------------------------------
// accumulation: one transaction per cycle while in_ready is high (square on a 17x17 multiplier)
// closing item: out_valid rises after the divide, normalize, square root, log squarings,
//   scale and round steps; a silent window skips the log squarings and scale, and an
//   empty one goes straight to the result
// input is not ready while the finishing math runs or a result waits
// rst_n is synchronous active low and clears all accumulators and control
module audio_rms_peak_dbfs_meter
  import arpm_pkg::*;
#(
  parameter int MAX_FRAMES = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  arpm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output arpm_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int DVD_W = SUM_W + 16;  // dividend bits

  typedef enum logic [2:0] {
    S_ACC, S_DIV, S_NORM, S_SQRT, S_LOG, S_SCALE, S_RND, S_OUT
  } state_t;

  state_t            state_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [16:0]       peak_r;
  logic [DVD_W-1:0]  quo_r;     // dividend shifting into quotient
  logic [CNT_W:0]    rem_r;
  logic [6:0]        step_r;
  logic [63:0]       m_r;       // mean square
  logic [63:0]       rv_r;      // sqrt remainder
  logic [31:0]       root_r;
  logic [5:0]        e_r;
  logic [31:0]       y_r;
  logic [15:0]       frac_r;
  logic [39:0]       prod_r;
  arpm_out_t         res_r;

  // sample magnitude and square
  logic [16:0] mag;
  logic [31:0] sq;
  logic        take;
  assign mag  = in_data.sample[15] ? (17'h10000 - {1'b0, in_data.sample})
                                   : {1'b0, in_data.sample};
  assign sq   = mag * mag;
  assign in_ready  = (state_r == S_ACC);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;
  assign take = in_data.has_sample && (cnt_r < CNT_W'(MAX_FRAMES));

  // restoring divide step
  logic [CNT_W:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[DVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, cnt_r};

  // sqrt step, bit = 4^step, trial = (root << (step + 1)) + bit
  logic [63:0] sbit, strial;
  assign sbit   = 64'd1 << {step_r[4:0], 1'b0};
  assign strial = (64'(root_r) << ({1'b0, step_r[4:0]} + 6'd1)) + sbit;

  // log squaring (31x31 -> 62, keep >>30)
  logic [61:0] ysq;
  logic [31:0] ysh;
  assign ysq = y_r[30:0] * y_r[30:0];
  assign ysh = ysq[61:30];

  // leading one of m
  logic [5:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < 64; i++) if (m_r[i]) lead = 6'(i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      sum_r   <= '0;
      cnt_r   <= '0;
      peak_r  <= '0;
    end else begin
      case (state_r)
        // accumulate frames
        S_ACC: if (in_valid) begin
          if (take) begin
            sum_r <= sum_r + SUM_W'(sq);
            cnt_r <= cnt_r + 1'b1;
            if (mag > peak_r) peak_r <= mag;
          end
          if (in_data.last) begin
            if (cnt_r == '0 && !take) begin
              res_r   <= '{24'd0, DB_FLOOR_Q8, 15'd0, 1'b0};
              state_r <= S_OUT;
            end else begin
              quo_r   <= {(take ? sum_r + SUM_W'(sq) : sum_r), 16'd0};
              rem_r   <= '0;
              step_r  <= '0;
              res_r.peak_abs <= ((take && mag > peak_r) ? mag : peak_r) > 17'd32767
                ? 15'h7fff : (((take && mag > peak_r) ? mag[14:0] : peak_r[14:0]));
              res_r.online <= 1'b1;
              state_r <= S_DIV;
            end
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          rem_r  <= rem_ge ? rem_sh - {1'b0, cnt_r} : rem_sh;
          quo_r  <= {quo_r[DVD_W-2:0], rem_ge};
          step_r <= step_r + 1'b1;
          if (step_r == 7'(DVD_W - 1)) state_r <= S_NORM;
        end
        S_NORM: begin
          m_r     <= quo_r[63:0];
          rv_r    <= quo_r[63:0];
          root_r  <= '0;
          step_r  <= 7'd31;
          state_r <= S_SQRT;
        end
        // one root bit per cycle
        S_SQRT: begin
          if (rv_r >= strial) begin
            rv_r   <= rv_r - strial;
            root_r <= root_r + (32'd1 << step_r[4:0]);
          end
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            e_r     <= lead;
            y_r     <= (lead >= 6'd30) ? 32'(m_r >> (lead - 6'd30))
                                       : 32'(m_r << (6'd30 - lead));
            frac_r  <= '0;
            step_r  <= '0;
            state_r <= (m_r == '0) ? S_RND : S_LOG;
          end
        end
        // one fraction bit per squaring
        S_LOG: begin
          frac_r <= {frac_r[14:0], ysh[31]};
          y_r    <= ysh[31] ? (ysh >> 1) : ysh;
          step_r <= step_r + 1'b1;
          if (step_r == 7'd15) state_r <= S_SCALE;
        end
        S_SCALE: begin
          res_r.rms_counts_q8 <= root_r[23:0];
          if ({e_r, frac_r} >= LOG_TOP_Q16) prod_r <= '0;
          else prod_r <= 40'(LOG_TOP_Q16 - {e_r, frac_r}) * DB_COEF_Q16 + 40'(1 << 23);
          state_r <= S_RND;
        end
        S_RND: begin
          if (m_r == '0) begin
            res_r.rms_counts_q8 <= '0;
            res_r.dbfs_q8 <= DB_FLOOR_Q8;
          end else if (prod_r[39:24] >= 16'd30720)
            res_r.dbfs_q8 <= DB_FLOOR_Q8;
          else res_r.dbfs_q8 <= -$signed({1'b0, prod_r[38:24]});
          state_r <= S_OUT;
        end
        // hold result until taken
        S_OUT: if (out_ready) begin
          sum_r   <= '0;
          cnt_r   <= '0;
          peak_r  <= '0;
          state_r <= S_ACC;
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

endmodule

### hw/rtl/arpm_checker.sv
// ----------------------------------------------------------------------------
// arpm_checker
// port level checks for the level meter
// ----------------------------------------------------------------------------
module arpm_checker
  import arpm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input arpm_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input arpm_out_t out_data
);

  // result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");

  // never take input while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready)) else $error("in/out overlap");

  // offline result is the floor
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.online |-> out_data.dbfs_q8 == DB_FLOOR_Q8 &&
    out_data.rms_counts_q8 == 24'd0) else $error("offline result");

  // non-last transaction keeps block ready
  a_cont: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.last |=> in_ready) else $error("ready dropped");

endmodule

bind audio_rms_peak_dbfs_meter arpm_checker u_arpm_checker (.*);

### test/audio_rms_peak_dbfs_meter_checker.sv
// ----------------------------------------------------------------------------
// audio_rms_peak_dbfs_meter_checker
// watches the input and output of the level meter, predicts each window result and
// compares it field by field against what the block delivers
// ----------------------------------------------------------------------------
module audio_rms_peak_dbfs_meter_checker
  import arpm_pkg::*;
#(
  parameter int MAX_FRAMES = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  arpm_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  arpm_out_t out_data,
  output int        mismatch_count,
  output int        windows_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // window accumulators of the predictor
  logic [63:0] energy_acc;
  int unsigned frame_cnt;
  logic [16:0] peak_mag;

  arpm_out_t level_queue[$];

  initial mismatch_count = 0;
  assign windows_pending = level_queue.size();

  function automatic logic [63:0] square_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] probe;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // log2 with 16 fraction bits by repeated squaring of a q30 mantissa
  function automatic logic [63:0] log2_fixed(logic [63:0] m);
    int unsigned ex;
    logic [63:0] y;
    logic [63:0] frac;
    ex = 0;
    frac = '0;
    while (ex < 63 && (m >> (ex + 1)) != 0) ex++;
    if (ex >= 30) y = m >> (ex - 30);
    else y = m << (30 - ex);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd1 << 31)) begin
        y >>= 1;
        frac |= 64'd1;
      end
    end
    return (64'(ex) << 16) | frac;
  endfunction

  function automatic logic signed [15:0] level_dbfs(logic [63:0] m);
    logic [63:0] lg;
    logic [63:0] span;
    logic [63:0] q;
    if (m == 0) return DB_FLOOR_Q8;
    lg = log2_fixed(m);
    if (lg >= 64'(LOG_TOP_Q16)) return 16'sd0;
    span = 64'(LOG_TOP_Q16) - lg;
    q = (span * 64'(DB_COEF_Q16) + (64'd1 << 23)) >> 24;
    if (q >= 64'd30720) return DB_FLOOR_Q8;
    return -$signed(16'(q));
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  // predict on every accepted input transaction
  always @(posedge clk) begin
    logic [16:0] mag;
    logic [63:0] mean_sq;
    arpm_out_t r;
    if (!rst_n) begin
      energy_acc <= '0;
      frame_cnt <= 0;
      peak_mag <= '0;
    end else if (in_valid && in_ready) begin
      logic [63:0] acc;
      int unsigned cnt;
      logic [16:0] pk;
      acc = energy_acc;
      cnt = frame_cnt;
      pk = peak_mag;
      if (in_data.has_sample && cnt < MAX_FRAMES) begin
        mag = in_data.sample[15] ? 17'h10000 - 17'(in_data.sample[15:0])
                                 : 17'(in_data.sample[15:0]);
        acc += 64'(mag) * 64'(mag);
        if (mag > pk) pk = mag;
        cnt++;
      end
      if (in_data.last) begin
        if (cnt == 0) begin
          r = '{rms_counts_q8: '0, dbfs_q8: DB_FLOOR_Q8, peak_abs: '0, online: 1'b0};
        end else begin
          mean_sq = (acc << 16) / 64'(cnt);
          r.rms_counts_q8 = 24'(square_root(mean_sq));
          r.dbfs_q8 = level_dbfs(mean_sq);
          r.peak_abs = (pk > 17'd32767) ? 15'd32767 : 15'(pk);
          r.online = 1'b1;
        end
        level_queue.push_back(r);
        acc = '0;
        cnt = 0;
        pk = '0;
      end
      energy_acc <= acc;
      frame_cnt <= cnt;
      peak_mag <= pk;
    end
  end

  // compare every accepted result transaction with the oldest prediction
  always @(posedge clk) begin
    arpm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (level_queue.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        mismatch_count++;
      end else begin
        want = level_queue.pop_front();
        if (out_data.rms_counts_q8 !== want.rms_counts_q8)
          report("rms_counts_q8", out_data.rms_counts_q8, want.rms_counts_q8);
        if (out_data.dbfs_q8 !== want.dbfs_q8)
          report("dbfs_q8", out_data.dbfs_q8, want.dbfs_q8);
        if (out_data.peak_abs !== want.peak_abs)
          report("peak_abs", out_data.peak_abs, want.peak_abs);
        if (out_data.online !== want.online)
          report("online", out_data.online, want.online);
      end
    end
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives frames and window closings into the level meter with random idling
// on both sides; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module testbench;
  import arpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES = 512;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  arpm_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  arpm_out_t out_data;
  int        mismatch_count;
  int        windows_pending;
  int        frames_sent = 0;
  bit        steady_sender = 0;
  bit        steady_receiver = 0;
  bit        hold_done = 0;

  audio_rms_peak_dbfs_meter #(.MAX_FRAMES(MAX_FRAMES)) uut (.*);

  audio_rms_peak_dbfs_meter_checker #(.MAX_FRAMES(MAX_FRAMES)) level_check (.*);

  // clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  initial begin
    #3000000;
    $display("testbench: done, errors");
    $finish;
  end

  // receiver: random ready gaps, one long hold-off while frames keep coming
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = steady_receiver ? 0 : $urandom_range(0, 9);
      if (!hold_done && frames_sent > 40) begin
        gap = 400;
        hold_done = 1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_frame(logic signed [15:0] smp, logic has, logic fin);
    int gap;
    gap = steady_sender ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample: smp, has_sample: has, last: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    int len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty window, extremes, silence, no-op item
    send_frame(16'sd0, 1'b0, 1'b1);
    send_frame(-16'sd32768, 1'b1, 1'b1);
    send_frame(16'sd32767, 1'b1, 1'b1);
    send_frame(16'sd0, 1'b1, 1'b1);
    send_frame(16'sd1, 1'b1, 1'b1);
    send_frame(-16'sd1, 1'b1, 1'b0);
    send_frame(16'sd5, 1'b0, 1'b0);
    send_frame(16'sd0, 1'b0, 1'b1);
    send_frame(16'sh5555, 1'b1, 1'b0);
    send_frame(-16'sh5556, 1'b1, 1'b0);
    send_frame(-16'sd32768, 1'b1, 1'b0);
    send_frame(16'sd32767, 1'b1, 1'b1);
    send_frame(16'sd0, 1'b1, 1'b0);
    send_frame(16'sd0, 1'b1, 1'b1);

    // random windows, mostly short, some with no idling at all
    for (int w = 0; w < 45; w++) begin
      steady_sender = ($urandom_range(0, 4) == 0);
      steady_receiver = ($urandom_range(0, 4) == 0);
      len = $urandom_range(0, 16);
      for (int i = 0; i < len; i++)
        send_frame(pick_sample(), $urandom_range(0, 9) != 0, 1'b0);
      send_frame(pick_sample(), $urandom_range(0, 1), 1'b1);
    end

    // overflowing window; the sample on the closing item is dropped
    steady_sender = 1;
    for (int i = 0; i < MAX_FRAMES + 3; i++)
      send_frame(pick_sample(), 1'b1, 1'b0);
    send_frame(-16'sd32768, 1'b1, 1'b1);
    steady_sender = 0;
    steady_receiver = 0;

    in_valid <= 1'b0;
    while (windows_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && windows_pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
